/* hdl/fac_pkg.sv */
`default_nettype none
package fac_pkg;

	localparam int ADDR_W       = 48;
	localparam int DEF_ENTRIES  = 16;
	localparam int DEF_LINE_B   = 64;
	localparam int DEF_ADDR_B   = 48;
	localparam int LC_W         = 5;
	localparam int POLICY_W     = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 5;
	localparam logic [LC_W-1:0] LC_RESET = 5'd16;

	typedef enum logic [POLICY_W-1:0] {
		POL_FIFO = 2'd0,
		POL_FILO = 2'd1,
		POL_LRU  = 2'd2
	} policy_t;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 1'b1;

	// decision for the item in the lookup stage
	typedef struct packed {
		logic hit;
		logic alloc;
		logic evict;
	} alloc_ctl_t;

endpackage
`default_nettype wire

/* hdl/fac_tag_store.sv */
`default_nettype none
module fac_tag_store #(
	parameter int ENTRIES = 16,
	parameter int TAG_W   = 42
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [TAG_W-1:0]   lookup_tag,
	input  wire fac_pkg::alloc_ctl_t ctl,
	input  wire logic [ENTRIES-1:0] slot_oh,
	output logic      [ENTRIES-1:0] match,
	output logic      [ENTRIES-1:0] line_valid,
	output logic      [TAG_W-1:0]   victim_tag
);
	import fac_pkg::*;

	logic [TAG_W-1:0] line_tag_q [ENTRIES];
	logic [ENTRIES-1:0] line_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
		end else if (ctl.alloc) begin
			line_valid_q <= line_valid_q | slot_oh;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (ctl.alloc && slot_oh[i]) begin
				line_tag_q[i] <= lookup_tag;
			end
		end
	end

	// parallel compare of every slot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = line_valid_q[i] && (line_tag_q[i] == lookup_tag);
		end
	end

	// slot_oh is one-hot on eviction, so an OR mux reads the victim
	always_comb begin
		victim_tag = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_oh[i]) begin
				victim_tag = victim_tag | line_tag_q[i];
			end
		end
	end

	assign line_valid = line_valid_q;

endmodule
`default_nettype wire

/* hdl/fac_rank.sv */
`default_nettype none
module fac_rank #(
	parameter int ENTRIES = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	input  wire fac_pkg::policy_t          policy,
	input  wire logic [fac_pkg::LC_W-1:0]  line_count,
	input  wire logic [ENTRIES-1:0]        match,
	input  wire logic [ENTRIES-1:0]        line_valid,
	output fac_pkg::alloc_ctl_t            ctl,
	output logic      [ENTRIES-1:0]        slot_oh
);
	import fac_pkg::*;

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int LW     = (CNT_W > LC_W) ? CNT_W : LC_W;

	logic [RANK_W-1:0] rank_q [ENTRIES];
	logic [RANK_W-1:0] rank_d [ENTRIES];
	logic [CNT_W-1:0]  filled_q;

	logic [LW-1:0]      lc_ext;
	logic [LW-1:0]      lim;
	logic               full;
	logic               hit;
	logic [RANK_W-1:0]  hit_rank;
	logic [RANK_W-1:0]  target;
	logic [ENTRIES-1:0] victim_oh;
	logic [ENTRIES-1:0] free_n;
	logic [ENTRIES-1:0] free_oh;

	assign lc_ext = LW'(line_count);

	always_comb begin
		if (lc_ext == '0) begin
			lim = LW'(1);
		end else if (lc_ext > LW'(ENTRIES)) begin
			lim = LW'(ENTRIES);
		end else begin
			lim = lc_ext;
		end
	end

	assign full = LW'(filled_q) >= lim;
	assign hit  = |match;

	always_comb begin
		hit_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	// valid ranks are always a permutation of 0..filled-1, so the victim
	// is the slot holding the extreme rank
	always_comb begin
		case (policy)
			POL_FILO: target = '0;
			default:  target = RANK_W'(filled_q - 1'b1);
		endcase
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			victim_oh[i] = line_valid[i] && (rank_q[i] == target);
		end
	end

	// lowest free slot
	assign free_n  = ~line_valid;
	assign free_oh = free_n & (~free_n + 1'b1);

	assign ctl.hit   = item_valid && hit;
	assign ctl.alloc = item_valid && !hit;
	assign ctl.evict = item_valid && !hit && full;
	assign slot_oh   = full ? victim_oh : free_oh;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
			if (ctl.hit) begin
				if (policy == POL_LRU && line_valid[i]) begin
					if (match[i]) begin
						rank_d[i] = '0;
					end else if (rank_q[i] < hit_rank) begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
			end else if (ctl.alloc) begin
				if (slot_oh[i]) begin
					rank_d[i] = '0;
				end else if (line_valid[i]) begin
					// drop the victim (close the gap), then age everyone
					if (full && rank_q[i] > target) begin
						rank_d[i] = rank_q[i];
					end else begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
			filled_q <= '0;
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
			if (ctl.alloc && !full) begin
				filled_q <= filled_q + 1'b1;
			end
		end
	end

	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(line_valid) == int'(filled_q))
		else $error("occupancy count out of step with valid bits");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(filled_q) <= ENTRIES)
		else $error("occupancy above capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.hit |-> $onehot(match))
		else $error("line present in more than one slot");

	a_single_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> $onehot(slot_oh))
		else $error("allocation without exactly one target slot");

endmodule
`default_nettype wire

/* hdl/fully_assoc_cache_replacement.sv */
// Fully associative tag store with FIFO, FILO or LRU replacement. One item
// (an access address) is taken per clock: busy stays low, so start may be
// held high every cycle. The lookup, victim choice and state update of an
// item happen in the cycle after it is accepted, in a single pass over all
// slots compared in parallel. Its result is on the ports with done high in
// the cycle after that. Results come in item order and cannot be
// stalled, so the receiver must take each one as it comes. The user must
// write configuration (policy, line_count) through cfg_we / cfg_idx /
// cfg_wdata only while no item is in flight; the block does not enforce
// this. After reset the store is empty, policy is FIFO and line_count is
// 16.
`default_nettype none
module fully_assoc_cache_replacement #(
	parameter int ENTRIES    = fac_pkg::DEF_ENTRIES,
	parameter int LINE_BYTES = fac_pkg::DEF_LINE_B,
	parameter int ADDR_BITS  = fac_pkg::DEF_ADDR_B
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [fac_pkg::ADDR_W-1:0]       addr,
	input  wire logic                             cfg_we,
	input  wire logic [fac_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [fac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                                  done,
	output logic                                  hit,
	output logic                                  victim_valid,
	output logic      [fac_pkg::ADDR_W-1:0]       victim_addr
);
	import fac_pkg::*;

	localparam int IN_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int OFF     = $clog2(LINE_BYTES);
	localparam int TAG_W   = IN_BITS - OFF;

	policy_t           policy_q;
	logic [LC_W-1:0]   line_count_q;
	logic [TAG_W-1:0]  tag_s1;
	logic              valid_s1;
	logic              done_q;
	logic              hit_q;
	logic              victim_valid_q;
	logic [ADDR_W-1:0] victim_addr_q;

	alloc_ctl_t         ctl;
	logic [ENTRIES-1:0] slot_oh;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] line_valid;
	logic [TAG_W-1:0]   victim_tag;
	logic [IN_BITS-1:0] victim_line;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= POL_FIFO;
			line_count_q <= LC_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_POLICY:     policy_q     <= policy_t'(cfg_wdata[POLICY_W-1:0]);
				CFG_LINE_COUNT: line_count_q <= cfg_wdata[LC_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage: keep only the line address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			tag_s1 <= addr[IN_BITS-1:OFF];
		end
	end

	fac_tag_store #(
		.ENTRIES (ENTRIES),
		.TAG_W   (TAG_W)
	) u_tags (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_tag (tag_s1),
		.ctl        (ctl),
		.slot_oh    (slot_oh),
		.match      (match),
		.line_valid (line_valid),
		.victim_tag (victim_tag)
	);

	fac_rank #(
		.ENTRIES (ENTRIES)
	) u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.policy     (policy_q),
		.line_count (line_count_q),
		.match      (match),
		.line_valid (line_valid),
		.ctl        (ctl),
		.slot_oh    (slot_oh)
	);

	assign victim_line = {victim_tag, {OFF{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		hit_q          <= ctl.hit;
		victim_valid_q <= ctl.evict;
		victim_addr_q  <= ctl.evict ? ADDR_W'(victim_line) : '0;
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign victim_valid = victim_valid_q;
	assign victim_addr  = victim_addr_q;

	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && victim_valid))
		else $error("hit reported together with a victim");

	a_victim_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !victim_valid) |-> (victim_addr == '0))
		else $error("victim address nonzero without a victim");

	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item produced no result");

endmodule
`default_nettype wire
